// ===== hw/rtl/cia_pkg.sv =====
`default_nettype none
package cia_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned CntWidth  = $clog2(DataWidth);

  // Operation codes
  typedef enum logic [2:0] {
    OP_ABS = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_MOD = 3'd5,
    OP_GCD = 3'd6,
    OP_LCM = 3'd7
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_DIVZ  = 2'd3
  } st_t;

  typedef struct packed {
    op_t                         kind;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    st_t                         status;
  } out_item_t;

  // Datapath commands, one per cycle
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV_AB,
    CMD_DIV_XY,
    CMD_DIV_YX,
    CMD_DIV_LCM,
    CMD_DIV_STEP,
    CMD_GCD_WB,
    CMD_MUL_AB,
    CMD_MUL_Q,
    CMD_MUL_STEP,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    op_t  op;
    logic last;
    logic a_zero;
    logic b_zero;
    logic a_min;
    logic b_min;
    logic gcd_done;
    logic x_gt_y;
    logic out_free;
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_DIV,
    S_DIVG,
    S_GWB,
    S_GCD,
    S_DIVL,
    S_MULQ,
    S_MUL,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cia_ctrl.sv =====
`default_nettype none
module cia_ctrl
  import cia_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output ctl_t       ctl
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl.cmd    = CMD_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cmd    = CMD_LOAD;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.op)
          OP_MUL: begin
            ctl.cmd    = CMD_MUL_AB;
            state_next = S_MUL;
          end
          OP_DIV, OP_MOD: begin
            if (stat.b_zero) begin
              state_next = S_FIN;
            end else begin
              ctl.cmd    = CMD_DIV_AB;
              state_next = S_DIV;
            end
          end
          OP_GCD: begin
            state_next = (stat.a_min || stat.b_min) ? S_FIN : S_GCD;
          end
          OP_LCM: begin
            if (stat.a_zero || stat.b_zero || stat.a_min || stat.b_min) state_next = S_FIN;
            else state_next = S_GCD;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_DIV: begin
        ctl.cmd = CMD_DIV_STEP;
        if (stat.last) state_next = S_FIN;
      end
      // Euclid: one remainder per pass through the divider
      S_GCD: begin
        if (stat.gcd_done) begin
          if (stat.op == OP_GCD) begin
            state_next = S_FIN;
          end else begin
            ctl.cmd    = CMD_DIV_LCM;
            state_next = S_DIVL;
          end
        end else begin
          ctl.cmd    = stat.x_gt_y ? CMD_DIV_XY : CMD_DIV_YX;
          state_next = S_DIVG;
        end
      end
      S_DIVG: begin
        ctl.cmd = CMD_DIV_STEP;
        if (stat.last) state_next = S_GWB;
      end
      S_GWB: begin
        ctl.cmd    = CMD_GCD_WB;
        state_next = S_GCD;
      end
      S_DIVL: begin
        ctl.cmd = CMD_DIV_STEP;
        if (stat.last) state_next = S_MULQ;
      end
      S_MULQ: begin
        ctl.cmd    = CMD_MUL_Q;
        state_next = S_MUL;
      end
      S_MUL: begin
        ctl.cmd = CMD_MUL_STEP;
        if (stat.last) state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          ctl.cmd    = CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cia_dp.sv =====
`default_nettype none
module cia_dp
  import cia_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t in_item,
  input  wire ctl_t     ctl,
  output stat_t         stat,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  localparam logic [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};

  op_t                  op;
  logic [DataWidth-1:0] a, b, ma, mb;
  logic [DataWidth-1:0] x, rem, d;
  logic [DataWidth-1:0] gx, gy;
  logic                 gsel;
  logic [DataWidth-1:0] mc, hi, lo;
  logic [CntWidth-1:0]  cnt;

  logic                 na, nb, neg;
  logic [DataWidth:0]   div_t1;
  logic                 div_ge;
  logic [DataWidth:0]   mul_s;

  assign na  = a[DataWidth-1];
  assign nb  = b[DataWidth-1];
  assign neg = na ^ nb;

  // Divider and multiplier step logic
  assign div_t1 = {rem, x[DataWidth-1]};
  assign div_ge = div_t1 >= {1'b0, d};
  assign mul_s  = {1'b0, hi} + (lo[0] ? {1'b0, mc} : '0);

  // Status to the controller
  always_comb begin
    stat.op       = op;
    stat.last     = (cnt == CntWidth'(DataWidth - 1));
    stat.a_zero   = (a == '0);
    stat.b_zero   = (b == '0);
    stat.a_min    = (a == MinVal);
    stat.b_min    = (b == MinVal);
    stat.gcd_done = (gx == '0) || (gy == '0);
    stat.x_gt_y   = gx > gy;
    stat.out_free = !out_valid || out_ready;
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_ABS;
    end else begin
      unique case (ctl.cmd)
        CMD_LOAD: begin
          op <= in_item.kind;
          a  <= in_item.operand_a;
          b  <= in_item.operand_b;
          ma <= in_item.operand_a[DataWidth-1] ? -in_item.operand_a : in_item.operand_a;
          mb <= in_item.operand_b[DataWidth-1] ? -in_item.operand_b : in_item.operand_b;
          gx <= in_item.operand_a[DataWidth-1] ? -in_item.operand_a : in_item.operand_a;
          gy <= in_item.operand_b[DataWidth-1] ? -in_item.operand_b : in_item.operand_b;
        end
        CMD_DIV_AB: begin
          x <= ma; d <= mb; rem <= '0; cnt <= '0;
        end
        CMD_DIV_XY: begin
          x <= gx; d <= gy; rem <= '0; cnt <= '0; gsel <= 1'b1;
        end
        CMD_DIV_YX: begin
          x <= gy; d <= gx; rem <= '0; cnt <= '0; gsel <= 1'b0;
        end
        CMD_DIV_LCM: begin
          x <= ma; d <= gx | gy; rem <= '0; cnt <= '0;
        end
        CMD_DIV_STEP: begin
          rem <= div_ge ? DataWidth'(div_t1 - {1'b0, d}) : div_t1[DataWidth-1:0];
          x   <= {x[DataWidth-2:0], div_ge};
          cnt <= cnt + 1'b1;
        end
        CMD_GCD_WB: begin
          if (gsel) gx <= rem;
          else      gy <= rem;
        end
        CMD_MUL_AB: begin
          mc <= ma; lo <= mb; hi <= '0; cnt <= '0;
        end
        CMD_MUL_Q: begin
          mc <= x; lo <= mb; hi <= '0; cnt <= '0;
        end
        CMD_MUL_STEP: begin
          hi  <= mul_s[DataWidth:1];
          lo  <= {mul_s[0], lo[DataWidth-1:1]};
          cnt <= cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Final value and status
  logic [DataWidth-1:0] sum, dif, v;
  logic                 p_gt_min, p_gt_max, p_eq_min;
  st_t                  st;

  assign sum      = a + b;
  assign dif      = a - b;
  assign p_gt_max = (hi != '0) || lo[DataWidth-1];
  assign p_eq_min = (hi == '0) && (lo == MinVal);
  assign p_gt_min = p_gt_max && !p_eq_min;

  always_comb begin
    v  = '0;
    st = ST_OK;
    unique case (op)
      OP_ABS: begin
        if (stat.a_min) st = ST_OVER;
        else            v  = ma;
      end
      OP_ADD: begin
        v = sum;
        if (na == nb && sum[DataWidth-1] != na) st = na ? ST_UNDER : ST_OVER;
      end
      OP_SUB: begin
        v = dif;
        if (na != nb && dif[DataWidth-1] != na) st = na ? ST_UNDER : ST_OVER;
      end
      OP_MUL: begin
        if (neg) begin
          if (p_gt_min) st = ST_UNDER;
          else          v  = -lo;
        end else begin
          if (p_gt_max) st = ST_OVER;
          else          v  = lo;
        end
      end
      OP_DIV: begin
        if (stat.b_zero)         st = ST_DIVZ;
        else if (neg)            v  = -x;
        else if (x[DataWidth-1]) st = ST_OVER;
        else                     v  = x;
      end
      OP_MOD: begin
        if (stat.b_zero)            st = ST_DIVZ;
        else if (na && rem != '0)   v  = mb - rem;
        else                        v  = rem;
      end
      OP_GCD: begin
        if (stat.a_min || stat.b_min) st = ST_OVER;
        else                          v  = gx | gy;
      end
      OP_LCM: begin
        if (stat.a_zero || stat.b_zero)     v  = '0;
        else if (stat.a_min || stat.b_min)  st = ST_OVER;
        else if (neg && p_gt_min)           st = ST_UNDER;
        else if (p_gt_max)                  st = ST_OVER;
        else                                v  = lo;
      end
      default: ;
    endcase
    if (st != ST_OK) v = '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.cmd == CMD_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_FINISH) begin
      out_item.value  <= $signed(v);
      out_item.status <= st;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/checked_integer_alu_top.sv =====
// Checked signed integer ALU, 64-bit operands.
// Input channel in_valid/in_ready/in_item carries an opcode (kind) and two
// signed operands; output channel out_valid/out_ready/out_item returns one
// value and a status per item. Faults give status overflow, underflow or
// division by zero, with value zero.
// One item is processed at a time; in_ready is high only while the
// controller is idle. How each operation is computed:
//   abs, add, sub, gcd/lcm faults, divide by zero: no divider or multiplier pass
//   mul: bit-serial shift-add multiplier, one bit per cycle
//   div, mod: restoring divider, one quotient bit per cycle
//   gcd: one divider pass per Euclid remainder step
//   lcm: gcd plus one division and one multiplication
// The shared radix-2 divider serves div, mod, gcd and lcm.
// The result sits in an output register; a new item is taken while it
// waits. If the receiver stalls, the next result holds in the controller
// until the output register frees.
// Reset (rst, synchronous) returns the controller to idle and clears
// out_valid.
`default_nettype none
module checked_integer_alu_top
  import cia_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  ctl_t  ctl;
  stat_t stat;

  cia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  cia_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // A faulted result always carries zero
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_OK |-> out_item.value == '0)
    else $error("fault result with nonzero value");

  // One item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
  import cia_pkg::*;

  localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_VAL = 64'h7fff_ffff_ffff_ffff;
  localparam int WATCHDOG_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        errors = 0;
  int        accepted = 0;
  int        checked = 0;
  int        idle_cycles = 0;

  checked_integer_alu_top u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] magnitude(logic [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
    while (x != 0 && y != 0) begin
      if (x > y) x = x % y;
      else y = y % x;
    end
    return x + y;
  endfunction

  // Signed product from magnitudes with range check
  function automatic logic [63:0] mul_checked(logic [63:0] ma, logic [63:0] mb, logic neg,
                                              inout st_t st);
    logic [63:0] lim;
    lim = neg ? MIN_VAL : MAX_VAL;
    if (ma == 0 || mb == 0) return 64'd0;
    if (mb > lim / ma) begin
      st = neg ? ST_UNDER : ST_OVER;
      return 64'd0;
    end
    return neg ? 64'd0 - ma * mb : ma * mb;
  endfunction

  function automatic out_item_t alu_result(in_item_t it);
    logic [63:0] a, b, ma, mb, v, r, g;
    logic na, nb;
    st_t st;
    out_item_t res;
    a = it.operand_a; b = it.operand_b;
    na = a[63]; nb = b[63];
    ma = magnitude(a); mb = magnitude(b);
    v = 0; st = ST_OK;
    case (it.kind)
      OP_ABS: if (ma > MAX_VAL) st = ST_OVER; else v = ma;
      OP_ADD: begin
        v = a + b;
        if (na == nb && v[63] != na) st = na ? ST_UNDER : ST_OVER;
      end
      OP_SUB: begin
        v = a - b;
        if (na != nb && v[63] != na) st = na ? ST_UNDER : ST_OVER;
      end
      OP_MUL: v = mul_checked(ma, mb, na != nb, st);
      OP_DIV: begin
        if (mb == 0) st = ST_DIVZ;
        else begin
          r = ma / mb;
          if (na != nb) v = 64'd0 - r;
          else if (r > MAX_VAL) st = ST_OVER;
          else v = r;
        end
      end
      OP_MOD: begin
        if (mb == 0) st = ST_DIVZ;
        else begin
          r = ma % mb;
          v = (na && r != 0) ? mb - r : r;
        end
      end
      OP_GCD: if (ma > MAX_VAL || mb > MAX_VAL) st = ST_OVER; else v = euclid_gcd(ma, mb);
      default: begin
        if (ma != 0 && mb != 0) begin
          if (ma > MAX_VAL || mb > MAX_VAL) st = ST_OVER;
          else begin
            g = euclid_gcd(ma, mb);
            v = mul_checked(ma / g, mb, na != nb, st);
            if (st == ST_OK && v[63]) begin
              r = magnitude(v);
              if (r > MAX_VAL) st = ST_OVER; else v = r;
            end
          end
        end
      end
    endcase
    if (st != ST_OK) v = 0;
    res.value = v;
    res.status = st;
    return res;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Operands biased toward small values and boundaries
  function automatic logic [63:0] rand_operand();
    logic [63:0] w;
    case ($urandom_range(0, 9))
      0: w = MIN_VAL;
      1: w = MAX_VAL;
      2: w = 64'd0;
      3: w = $urandom_range(0, 1) ? 64'd1 : 64'hffff_ffff_ffff_ffff;
      4, 5: w = rand_word();
      6: w = rand_word() >> $urandom_range(1, 63);
      default: begin
        w = 64'($urandom_range(0, 5000));
        if ($urandom_range(0, 1)) w = 64'd0 - w;
      end
    endcase
    return w;
  endfunction

  task automatic add_item(op_t k, logic [63:0] a, logic [63:0] b);
    in_item_t it;
    it.kind = k; it.operand_a = a; it.operand_b = b;
    pending_items.push_back(it);
  endtask

  // Driver: holds valid with payload until accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(alu_result(in_item));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("testbench failed");
        $finish;
      end
      if (out_valid && out_ready) begin
        checked++;
        if (expected_results.size() == 0) begin
          $error("unexpected result value=%h status=%0d", out_item.value, out_item.status);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_item.value !== exp_res.value) begin
            $error("value expected %h actual %h", exp_res.value, out_item.value);
            errors++;
          end
          if (out_item.status !== exp_res.status) begin
            $error("status expected %0d actual %0d", exp_res.status, out_item.status);
            errors++;
          end
        end
      end
    end
  end

  // Checked away from the rising edge so driver and monitor updates have settled
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    op_t k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: boundaries and each special case
    add_item(OP_ABS, MIN_VAL, 0);
    add_item(OP_ABS, MAX_VAL, 0);
    add_item(OP_ABS, 64'hffff_ffff_ffff_fffb, MIN_VAL);
    add_item(OP_ADD, MAX_VAL, 1);
    add_item(OP_ADD, MIN_VAL, 64'hffff_ffff_ffff_ffff);
    add_item(OP_SUB, 0, MIN_VAL);
    add_item(OP_SUB, MIN_VAL, 1);
    add_item(OP_MUL, MIN_VAL, 0);
    add_item(OP_MUL, MAX_VAL, 2);
    add_item(OP_MUL, MAX_VAL, 64'hffff_ffff_ffff_fffe);
    add_item(OP_MUL, 64'h4000_0000_0000_0000, 64'hffff_ffff_ffff_fffe);
    add_item(OP_DIV, 7, 0);
    add_item(OP_DIV, MIN_VAL, 64'hffff_ffff_ffff_ffff);
    add_item(OP_DIV, 64'hffff_ffff_ffff_fff9, 2);
    add_item(OP_MOD, 5, 0);
    add_item(OP_MOD, 64'hffff_ffff_ffff_fff9, 64'hffff_ffff_ffff_fffd);
    add_item(OP_MOD, MIN_VAL, 64'hffff_ffff_ffff_ffff);
    add_item(OP_GCD, MIN_VAL, 4);
    add_item(OP_GCD, 0, 0);
    add_item(OP_GCD, 64'hffff_ffff_ffff_ffdc, 24);
    add_item(OP_LCM, 0, MIN_VAL);
    add_item(OP_LCM, MIN_VAL, 3);
    add_item(OP_LCM, 64'hffff_ffff_ffff_fffa, 4);
    add_item(OP_LCM, 64'h4000_0000_0000_0000, 64'hffff_ffff_ffff_fffe);
    add_item(OP_LCM, MAX_VAL, MAX_VAL - 1);
    drain();

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 63 : (ph == 3) ? 14 : 0;
      recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 14 : 0;
      for (int i = 0; i < 470; i++) begin
        k = op_t'($urandom_range(0, 7));
        add_item(k, rand_operand(), rand_operand());
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);

    $display("ran %0d items through all eight operations, %0d results checked", accepted,
             checked);
    $display("idle phases: none, sender 63%%, receiver 63%%, both 14%%");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
